[rtl/core/imhq_pkg.sv]
`timescale 1ns / 1ps
// shared constants for the indexed min-heap threshold query block
// no dependencies
package imhq_pkg;

  localparam int HEIGHT_W        = 32;
  localparam int PORT_ID_W       = 11;
  localparam int OP_W            = 2;
  localparam int MAX_ENTRIES_DEF = 1024;

  localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
  localparam logic [OP_W-1:0] OP_DECREASE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND     = 2'd2;

  // write enables from the sequencer to the heap storage
  typedef struct packed {
    logic ent_we;
    logic sid_we;
  } store_we_t;

endpackage

[rtl/core/imhq_store.sv]
`timescale 1ns / 1ps
// heap slot memory (height, id) and id-to-slot memory, registered reads
// depends on imhq_pkg
module imhq_store #(
  parameter int SW = 11
) (
  input  logic                               clk,
  input  imhq_pkg::store_we_t                we,
  input  logic [SW-1:0]                      ent_waddr,
  input  logic signed [imhq_pkg::HEIGHT_W-1:0] ent_wh,
  input  logic [SW-1:0]                      ent_wid,
  input  logic [SW-1:0]                      ent_raddr,
  output logic signed [imhq_pkg::HEIGHT_W-1:0] ent_rh,
  output logic [SW-1:0]                      ent_rid,
  input  logic [SW-1:0]                      sid_waddr,
  input  logic [SW-1:0]                      sid_wdata,
  input  logic [SW-1:0]                      sid_raddr,
  output logic [SW-1:0]                      sid_rdata
);

  localparam int DEPTH = 1 << SW;

  logic [imhq_pkg::HEIGHT_W-1:0] h_mem [DEPTH];
  logic [SW-1:0]                 id_mem [DEPTH];
  logic [SW-1:0]                 sid_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we.ent_we) begin
      h_mem[ent_waddr]  <= ent_wh;
      id_mem[ent_waddr] <= ent_wid;
    end
    ent_rh  <= h_mem[ent_raddr];
    ent_rid <= id_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.sid_we) begin
      sid_mem[sid_waddr] <= sid_wdata;
    end
    sid_rdata <= sid_mem[sid_raddr];
  end

endmodule

[rtl/core/indexed_min_heap_threshold_query.sv]
`timescale 1ns / 1ps
// indexed min-heap of (height, id) with decrease-key and threshold find
// load: places the entry at the next free slot and climbs toward the root, then writes it back
// decrease: reads slot and entry, saturating subtract, climbs up, sifts down, then writes back
// find: scans every stored entry for the smallest (height, id) above threshold, then issues a result word
// one word at a time, in_stall high until the operation ends; rst (sync) empties the heap, not memory
// depends on imhq_pkg, imhq_store
module indexed_min_heap_threshold_query #(
  parameter int MAX_ENTRIES = imhq_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [imhq_pkg::OP_W-1:0]             op,
  input  logic [imhq_pkg::PORT_ID_W-1:0]        item_id,
  input  logic signed [imhq_pkg::HEIGHT_W-1:0]  load_height,
  input  logic signed [imhq_pkg::HEIGHT_W-1:0]  decrease_amount,
  input  logic signed [imhq_pkg::HEIGHT_W-1:0]  threshold,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [imhq_pkg::PORT_ID_W-1:0]        found_id,
  output logic                                  found
);

  localparam int SW = $clog2(MAX_ENTRIES + 1);
  localparam int HW = imhq_pkg::HEIGHT_W;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DSLOT = 4'd1;  // read slot of id
  localparam logic [3:0] S_DENT  = 4'd2;  // read entry at that slot
  localparam logic [3:0] S_DCALC = 4'd3;  // saturating subtract
  localparam logic [3:0] S_UP    = 4'd4;  // issue parent read
  localparam logic [3:0] S_UPC   = 4'd5;  // compare with parent
  localparam logic [3:0] S_DN    = 4'd6;  // issue left child read
  localparam logic [3:0] S_DNL   = 4'd7;  // left child back, issue right
  localparam logic [3:0] S_DNR   = 4'd8;  // right child back, choose
  localparam logic [3:0] S_WB    = 4'd9;  // drop held entry into the hole
  localparam logic [3:0] S_SCAN  = 4'd10; // issue slot read
  localparam logic [3:0] S_SCMP  = 4'd11; // compare against best so far
  localparam logic [3:0] S_OUT   = 4'd12; // hand result to output register

  logic [3:0]           state;
  logic [SW-1:0]        count;
  logic [SW-1:0]        hole;       // slot the held entry currently sits over
  logic signed [HW-1:0] cur_h;
  logic [SW-1:0]        cur_id;
  logic                 is_dec;
  logic signed [HW-1:0] amount;
  logic signed [HW-1:0] th;
  logic [SW-1:0]        idx;
  logic                 best_v;
  logic signed [HW-1:0] best_h;
  logic [SW-1:0]        best_id;
  logic signed [HW-1:0] lft_h;
  logic [SW-1:0]        lft_id;

  // storage interface
  imhq_pkg::store_we_t  we;
  logic [SW-1:0]        ent_waddr;
  logic signed [HW-1:0] ent_wh;
  logic [SW-1:0]        ent_wid;
  logic [SW-1:0]        ent_raddr;
  logic signed [HW-1:0] ent_rh;
  logic [SW-1:0]        ent_rid;
  logic [SW-1:0]        sid_waddr;
  logic [SW-1:0]        sid_wdata;
  logic [SW-1:0]        sid_rdata;

  logic                 in_acc;
  logic [SW:0]          lc;
  logic [SW:0]          rc;
  logic                 has_l;
  logic                 has_r;
  logic [HW:0]          diff;
  logic signed [HW-1:0] sat_h;
  logic                 q_before_cur;   // memory word orders before held entry
  logic                 cur_before_q;   // held entry orders before memory word
  logic                 q_before_lft;
  logic                 lft_before_cur;
  logic                 q_before_best;
  logic                 id_ok;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign lc    = {hole, 1'b0};
  assign rc    = lc + {{SW{1'b0}}, 1'b1};
  assign has_l = (lc <= {1'b0, count});
  assign has_r = (rc <= {1'b0, count});

  // (height, id) ordering with the smaller id winning ties
  assign q_before_cur   = (ent_rh < cur_h) || ((ent_rh == cur_h) && (ent_rid < cur_id));
  assign cur_before_q   = (cur_h < ent_rh) || ((cur_h == ent_rh) && (cur_id < ent_rid));
  assign q_before_lft   = (ent_rh < lft_h) || ((ent_rh == lft_h) && (ent_rid < lft_id));
  assign lft_before_cur = (lft_h < cur_h) || ((lft_h == cur_h) && (lft_id < cur_id));
  assign q_before_best  = (ent_rh < best_h) || ((ent_rh == best_h) && (ent_rid < best_id));

  // saturating subtract on one extra bit
  assign diff  = {ent_rh[HW-1], ent_rh} - {amount[HW-1], amount};
  assign sat_h = (diff[HW] != diff[HW-1]) ?
                 (diff[HW] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}}) :
                 diff[HW-1:0];

  assign id_ok = (item_id != '0) && (32'(item_id) <= 32'(count));

  // read address and write controls by state
  always_comb begin
    we        = '0;
    ent_waddr = hole;
    ent_wh    = cur_h;
    ent_wid   = cur_id;
    sid_waddr = cur_id;
    sid_wdata = hole;
    ent_raddr = idx;
    case (state)
      S_DENT:  ent_raddr = sid_rdata;
      S_UP:    ent_raddr = hole >> 1;
      S_UPC: begin
        if (cur_before_q) begin
          // parent moves down into the hole
          we.ent_we = 1'b1;
          we.sid_we = 1'b1;
          ent_wh    = ent_rh;
          ent_wid   = ent_rid;
          sid_waddr = ent_rid;
        end
      end
      S_DN:    ent_raddr = lc[SW-1:0];
      S_DNL:   ent_raddr = rc[SW-1:0];
      S_DNR: begin
        if (has_r && q_before_lft) begin
          if (q_before_cur) begin
            we.ent_we = 1'b1;
            we.sid_we = 1'b1;
            ent_wh    = ent_rh;
            ent_wid   = ent_rid;
            sid_waddr = ent_rid;
          end
        end else if (lft_before_cur) begin
          we.ent_we = 1'b1;
          we.sid_we = 1'b1;
          ent_wh    = lft_h;
          ent_wid   = lft_id;
          sid_waddr = lft_id;
        end
      end
      S_WB: begin
        we.ent_we = 1'b1;
        we.sid_we = 1'b1;
      end
      default: ;
    endcase
  end

  imhq_store #(.SW(SW)) u_store (
    .clk       (clk),
    .we        (we),
    .ent_waddr (ent_waddr),
    .ent_wh    (ent_wh),
    .ent_wid   (ent_wid),
    .ent_raddr (ent_raddr),
    .ent_rh    (ent_rh),
    .ent_rid   (ent_rid),
    .sid_waddr (sid_waddr),
    .sid_wdata (sid_wdata),
    .sid_raddr (cur_id),
    .sid_rdata (sid_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result loaded in S_OUT takes the place of a consumed one
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (op)
              imhq_pkg::OP_LOAD: begin
                if (32'(count) < 32'(MAX_ENTRIES)) begin
                  count  <= count + 1'b1;
                  hole   <= count + 1'b1;
                  cur_id <= count + 1'b1;
                  cur_h  <= load_height;
                  is_dec <= 1'b0;
                  state  <= S_UP;
                end
              end
              imhq_pkg::OP_DECREASE: begin
                if (id_ok) begin
                  cur_id <= SW'(item_id);
                  amount <= decrease_amount;
                  is_dec <= 1'b1;
                  state  <= S_DSLOT;
                end
              end
              imhq_pkg::OP_FIND: begin
                th     <= threshold;
                idx    <= {{(SW-1){1'b0}}, 1'b1};
                best_v <= 1'b0;
                state  <= (count == '0) ? S_OUT : S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_DSLOT: state <= S_DENT;
        S_DENT: begin
          hole  <= sid_rdata;
          state <= S_DCALC;
        end
        S_DCALC: begin
          cur_h <= sat_h;
          state <= S_UP;
        end
        S_UP: begin
          if (hole <= {{(SW-1){1'b0}}, 1'b1}) begin
            state <= is_dec ? S_DN : S_WB;
          end else begin
            state <= S_UPC;
          end
        end
        S_UPC: begin
          if (cur_before_q) begin
            hole  <= hole >> 1;
            state <= S_UP;
          end else begin
            state <= is_dec ? S_DN : S_WB;
          end
        end
        S_DN:    state <= has_l ? S_DNL : S_WB;
        S_DNL: begin
          lft_h  <= ent_rh;
          lft_id <= ent_rid;
          state  <= S_DNR;
        end
        S_DNR: begin
          if (has_r && q_before_lft) begin
            if (q_before_cur) begin
              hole  <= rc[SW-1:0];
              state <= S_DN;
            end else begin
              state <= S_WB;
            end
          end else if (lft_before_cur) begin
            hole  <= lc[SW-1:0];
            state <= S_DN;
          end else begin
            state <= S_WB;
          end
        end
        S_WB:    state <= S_IDLE;
        S_SCAN:  state <= S_SCMP;
        S_SCMP: begin
          if ((ent_rh > th) && (!best_v || q_before_best)) begin
            best_v  <= 1'b1;
            best_h  <= ent_rh;
            best_id <= ent_rid;
          end
          if (idx == count) begin
            state <= S_OUT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SCAN;
          end
        end
        S_OUT: begin
          // waits while the previous result word is still held
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            found     <= best_v;
            found_id  <= best_v ? imhq_pkg::PORT_ID_W'(best_id) : '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
